// File: design/rc6_pkg.sv
// Shared constants, types and rotate helpers for the RC6 block decryption core.
package rc6_pkg;

	localparam int ROUNDS        = 20;
	localparam int MAX_KEY_WORDS = 8;
	localparam int TABLE_SIZE    = 2 * ROUNDS + 4;
	localparam int PAIRS         = ROUNDS + 2;
	localparam int MIX_ITERS     = 3 * ((TABLE_SIZE > MAX_KEY_WORDS) ? TABLE_SIZE : MAX_KEY_WORDS);
	localparam int KEY_PARTS     = 4;

	localparam int WORD_W     = 32;
	localparam int PAIR_W     = $clog2(PAIRS);
	localparam int ADDR_W     = PAIR_W + 1;
	localparam int ITER_W     = $clog2(MIX_ITERS);
	localparam int KW_IDX_W   = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
	localparam int KW_CNT_W   = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [WORD_W-1:0] MAGIC_P = 32'hB7E1_5163;
	localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9E37_79B9;
	localparam logic [4:0]        LG_W    = 5'd5;
	localparam logic [4:0]        KEY_ROT = 5'd3;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_LAST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_COUNT = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_MIX_A,
		ST_MIX_B,
		ST_DEC
	} ctrl_state_t;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_FILL,
		DP_MIX_A,
		DP_MIX_B,
		DP_LOAD,
		DP_POST,
		DP_ROUND,
		DP_PRE
	} dp_op_t;

	typedef struct packed {
		dp_op_t              op;
		logic                start;
		logic [ADDR_W-1:0]   wr_addr;
		logic [ADDR_W-1:0]   rd_addr0;
		logic [ADDR_W-1:0]   rd_addr1;
		logic [KW_IDX_W-1:0] l_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [KW_CNT_W-1:0] key_words;
	} dp_status_t;

	function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
		input logic [4:0] n);
		logic [2*WORD_W-1:0] dbl;
		dbl = {x, x} << n;
		return dbl[2*WORD_W-1:WORD_W];
	endfunction

	function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
		input logic [4:0] n);
		logic [2*WORD_W-1:0] dbl;
		dbl = {x, x} >> n;
		return dbl[WORD_W-1:0];
	endfunction

endpackage

// File: design/rc6_if.sv
// Valid/ready stream interfaces for ciphertext requests and plaintext results.
interface rc6_cipher_if;
	logic        valid;
	logic        ready;
	logic [31:0] cipher_a;
	logic [31:0] cipher_b;
	logic [31:0] cipher_c;
	logic [31:0] cipher_d;

	modport source (output valid, cipher_a, cipher_b, cipher_c, cipher_d, input ready);
	modport sink (input valid, cipher_a, cipher_b, cipher_c, cipher_d, output ready);
endinterface

interface rc6_plain_if;
	logic        valid;
	logic        ready;
	logic [31:0] plain_a;
	logic [31:0] plain_b;
	logic [31:0] plain_c;
	logic [31:0] plain_d;

	modport source (output valid, plain_a, plain_b, plain_c, plain_d, input ready);
	modport sink (input valid, plain_a, plain_b, plain_c, plain_d, output ready);
endinterface

// File: design/rc6_block_decrypt_core.sv
// Top level of the RC6-32/20 ECB block decryption core.
//
//   Port      Role     Contents
//   cipher    sink     ciphertext words cipher_a..cipher_d, one request per block
//   plain     source   plaintext words plain_a..plain_d, one per request
//   cfg_*     write    key_part_0..3 (indexes 0-3), key_word_count (index 4)
//
// A request is accepted in its load cycle and is then taken through post-whitening,
// 20 rounds and pre-whitening; no new request is accepted until pre-whitening ends.
// After reset or a key register write, an idle state and the key schedule (filling all
// 44 table entries, then 132 MIX_A/MIX_B mixing steps) run before the next request.
// A finished block waits in the output register; the next request is accepted
// meanwhile and stalls only at its last step while that register is still full.
module rc6_block_decrypt_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rc6_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rc6_pkg::CFG_DATA_W-1:0] cfg_data,
	rc6_cipher_if.sink                    cipher,
	rc6_plain_if.source                   plain
);

	rc6_pkg::dp_cmd_t    cmd;
	rc6_pkg::dp_status_t status;

	rc6_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.in_valid  (cipher.valid),
		.in_ready  (cipher.ready),
		.out_valid (plain.valid),
		.out_ready (plain.ready),
		.cmd       (cmd),
		.status    (status)
	);

	rc6_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.cipher_a  (cipher.cipher_a),
		.cipher_b  (cipher.cipher_b),
		.cipher_c  (cipher.cipher_c),
		.cipher_d  (cipher.cipher_d),
		.plain_a   (plain.plain_a),
		.plain_b   (plain.plain_b),
		.plain_c   (plain.plain_c),
		.plain_d   (plain.plain_d)
	);

endmodule

// File: design/rc6_datapath.sv
// Datapath: key registers, round key memory, key schedule and decryption rounds.
module rc6_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [rc6_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rc6_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  rc6_pkg::dp_cmd_t                 cmd,
	output rc6_pkg::dp_status_t              status,
	input  logic [31:0]                      cipher_a,
	input  logic [31:0]                      cipher_b,
	input  logic [31:0]                      cipher_c,
	input  logic [31:0]                      cipher_d,
	output logic [31:0]                      plain_a,
	output logic [31:0]                      plain_b,
	output logic [31:0]                      plain_c,
	output logic [31:0]                      plain_d
);

	logic [rc6_pkg::CFG_DATA_W-1:0] key_part_q [rc6_pkg::KEY_PARTS];
	logic [rc6_pkg::KW_CNT_W-1:0]   kwc_q;
	logic [31:0]                    l_q [rc6_pkg::MAX_KEY_WORDS];
	logic [31:0]                    sk_mem [rc6_pkg::TABLE_SIZE];
	logic [31:0]                    rd0_q, rd1_q;
	logic [31:0]                    acc_q, ka_q, kb_q;
	logic [31:0]                    a_q, b_q, c_q, d_q;
	logic [31:0]                    pa_q, pb_q, pc_q, pd_q;

	logic [31:0] fill_val, mix_a_val, mix_b_val, sum_ab, wr_data;
	logic        mem_we;
	logic [31:0] t_prod, u_prod, t_rot, u_rot, round_a, round_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < rc6_pkg::KEY_PARTS; k++) begin
				key_part_q[k] <= '0;
			end
			kwc_q <= rc6_pkg::KW_CNT_W'(4);
		end else if (cfg_wr_en) begin
			if (cfg_index <= rc6_pkg::REG_KEY_PART_LAST) begin
				key_part_q[cfg_index[1:0]] <= cfg_data;
			end else if (cfg_index == rc6_pkg::REG_KEY_WORD_COUNT) begin
				kwc_q <= cfg_data[rc6_pkg::KW_CNT_W-1:0];
			end
		end
	end

	always_comb begin
		if (kwc_q == '0) begin
			status.key_words = rc6_pkg::KW_CNT_W'(1);
		end else if (kwc_q > rc6_pkg::KW_CNT_W'(rc6_pkg::MAX_KEY_WORDS)) begin
			status.key_words = rc6_pkg::KW_CNT_W'(rc6_pkg::MAX_KEY_WORDS);
		end else begin
			status.key_words = kwc_q;
		end
	end

	assign fill_val  = cmd.start ? rc6_pkg::MAGIC_P : acc_q;
	assign mix_a_val = rc6_pkg::rotl32(rd0_q + ka_q + kb_q, rc6_pkg::KEY_ROT);
	assign sum_ab    = ka_q + kb_q;
	assign mix_b_val = rc6_pkg::rotl32(l_q[cmd.l_idx] + sum_ab, sum_ab[4:0]);
	assign mem_we    = (cmd.op == rc6_pkg::DP_FILL) || (cmd.op == rc6_pkg::DP_MIX_A);
	assign wr_data   = (cmd.op == rc6_pkg::DP_FILL) ? fill_val : mix_a_val;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sk_mem[cmd.wr_addr] <= wr_data;
		end
		rd0_q <= sk_mem[cmd.rd_addr0];
		rd1_q <= sk_mem[cmd.rd_addr1];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			rc6_pkg::DP_FILL: begin
				acc_q <= fill_val + rc6_pkg::MAGIC_Q;
				if (cmd.start) begin
					ka_q <= '0;
					kb_q <= '0;
					for (int k = 0; k < rc6_pkg::MAX_KEY_WORDS; k++) begin
						l_q[k] <= key_part_q[k >> 1][32 * (k & 1) +: 32];
					end
				end
			end
			rc6_pkg::DP_MIX_A: begin
				ka_q <= mix_a_val;
			end
			rc6_pkg::DP_MIX_B: begin
				kb_q <= mix_b_val;
				l_q[cmd.l_idx] <= mix_b_val;
			end
			default: begin
			end
		endcase
	end

	assign t_prod  = a_q * {a_q[30:0], 1'b1};
	assign u_prod  = c_q * {c_q[30:0], 1'b1};
	assign t_rot   = rc6_pkg::rotl32(t_prod, rc6_pkg::LG_W);
	assign u_rot   = rc6_pkg::rotl32(u_prod, rc6_pkg::LG_W);
	assign round_a = rc6_pkg::rotr32(d_q - rd0_q, u_rot[4:0]) ^ t_rot;
	assign round_c = rc6_pkg::rotr32(b_q - rd1_q, t_rot[4:0]) ^ u_rot;

	always_ff @(posedge clk) begin
		case (cmd.op)
			rc6_pkg::DP_LOAD: begin
				a_q <= cipher_a;
				b_q <= cipher_b;
				c_q <= cipher_c;
				d_q <= cipher_d;
			end
			rc6_pkg::DP_POST: begin
				a_q <= a_q - rd0_q;
				c_q <= c_q - rd1_q;
			end
			rc6_pkg::DP_ROUND: begin
				a_q <= round_a;
				b_q <= a_q;
				c_q <= round_c;
				d_q <= c_q;
			end
			rc6_pkg::DP_PRE: begin
				pa_q <= a_q;
				pb_q <= b_q - rd0_q;
				pc_q <= c_q;
				pd_q <= d_q - rd1_q;
			end
			default: begin
			end
		endcase
	end

	assign plain_a = pa_q;
	assign plain_b = pb_q;
	assign plain_c = pc_q;
	assign plain_d = pd_q;

endmodule

// File: design/rc6_ctrl.sv
// Controller: sequences key expansion and block decryption and owns the handshakes.
module rc6_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rc6_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rc6_pkg::dp_cmd_t              cmd,
	input  rc6_pkg::dp_status_t           status
);

	localparam logic [rc6_pkg::PAIR_W-1:0] LastPair = rc6_pkg::PAIR_W'(rc6_pkg::PAIRS - 1);
	localparam logic [rc6_pkg::ADDR_W-1:0] LastAddr =
		rc6_pkg::ADDR_W'(rc6_pkg::TABLE_SIZE - 1);
	localparam logic [rc6_pkg::ITER_W-1:0] LastIter =
		rc6_pkg::ITER_W'(rc6_pkg::MIX_ITERS - 1);

	rc6_pkg::ctrl_state_t          state_q, state_d;
	logic [rc6_pkg::ADDR_W-1:0]    idx_q, idx_d, idx_wrap;
	logic [rc6_pkg::KW_IDX_W-1:0]  j_q, j_d, j_wrap;
	logic [rc6_pkg::ITER_W-1:0]    iter_q, iter_d;
	logic [rc6_pkg::PAIR_W-1:0]    pair_q, pair_d, rd_pair;
	logic                          sched_ready_q, sched_ready_d;
	logic                          out_valid_q, out_set;
	logic                          cfg_hit;

	assign cfg_hit  = cfg_wr_en && (cfg_index <= rc6_pkg::REG_KEY_WORD_COUNT);
	assign idx_wrap = (idx_q == LastAddr) ? '0 : idx_q + 1'b1;
	assign j_wrap   = ((rc6_pkg::KW_CNT_W'(j_q) + 1'b1) == status.key_words) ? '0 : j_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= rc6_pkg::ST_IDLE;
			idx_q         <= '0;
			j_q           <= '0;
			iter_q        <= '0;
			pair_q        <= '0;
			sched_ready_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			idx_q         <= idx_d;
			j_q           <= j_d;
			iter_q        <= iter_d;
			pair_q        <= pair_d;
			sched_ready_q <= sched_ready_d;
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		j_d           = j_q;
		iter_d        = iter_q;
		pair_d        = pair_q;
		sched_ready_d = sched_ready_q;
		out_set       = 1'b0;
		in_ready      = 1'b0;
		rd_pair       = LastPair;
		cmd.op        = rc6_pkg::DP_NOP;
		cmd.start     = 1'b0;
		cmd.wr_addr   = idx_q;
		cmd.l_idx     = j_q;
		cmd.rd_addr0  = {LastPair, 1'b0};
		cmd.rd_addr1  = {LastPair, 1'b1};

		case (state_q)
			rc6_pkg::ST_IDLE: begin
				in_ready = sched_ready_q;
				if (!sched_ready_q) begin
					idx_d   = '0;
					state_d = rc6_pkg::ST_FILL;
				end else if (in_valid) begin
					cmd.op  = rc6_pkg::DP_LOAD;
					pair_d  = LastPair;
					state_d = rc6_pkg::ST_DEC;
				end
			end
			rc6_pkg::ST_FILL: begin
				cmd.op       = rc6_pkg::DP_FILL;
				cmd.start    = (idx_q == '0);
				cmd.rd_addr0 = '0;
				idx_d        = idx_wrap;
				if (idx_q == LastAddr) begin
					j_d     = '0;
					iter_d  = '0;
					state_d = rc6_pkg::ST_MIX_A;
				end
			end
			rc6_pkg::ST_MIX_A: begin
				cmd.op       = rc6_pkg::DP_MIX_A;
				cmd.rd_addr0 = idx_wrap;
				idx_d        = idx_wrap;
				state_d      = rc6_pkg::ST_MIX_B;
			end
			rc6_pkg::ST_MIX_B: begin
				cmd.op       = rc6_pkg::DP_MIX_B;
				cmd.rd_addr0 = idx_q;
				j_d          = j_wrap;
				iter_d       = iter_q + 1'b1;
				if (iter_q == LastIter) begin
					sched_ready_d = 1'b1;
					state_d       = rc6_pkg::ST_IDLE;
				end else begin
					state_d = rc6_pkg::ST_MIX_A;
				end
			end
			rc6_pkg::ST_DEC: begin
				rd_pair      = (pair_q == '0) ? '0 : pair_q - 1'b1;
				cmd.rd_addr0 = {rd_pair, 1'b0};
				cmd.rd_addr1 = {rd_pair, 1'b1};
				if (pair_q == LastPair) begin
					cmd.op = rc6_pkg::DP_POST;
					pair_d = pair_q - 1'b1;
				end else if (pair_q != '0) begin
					cmd.op = rc6_pkg::DP_ROUND;
					pair_d = pair_q - 1'b1;
				end else if (!out_valid_q || out_ready) begin
					cmd.op  = rc6_pkg::DP_PRE;
					out_set = 1'b1;
					state_d = rc6_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rc6_pkg::ST_IDLE;
			end
		endcase

		if (cfg_hit) begin
			sched_ready_d = 1'b0;
			state_d       = rc6_pkg::ST_IDLE;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: test/tb.sv
// Self-checking testbench for the RC6-32/20 block decryption core with its own key schedule model.
`timescale 1ns / 100ps

module tb;
	import rc6_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_MAX  = 3'd7;
	localparam int                   BLOCK_LATENCY  = 30;

	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
	} block_words_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rc6_cipher_if cipher_bus ();
	rc6_plain_if  plain_bus ();

	rc6_block_decrypt_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cipher    (cipher_bus),
		.plain     (plain_bus)
	);

	logic [CFG_DATA_W-1:0] key_parts [KEY_PARTS];
	logic [KW_CNT_W-1:0]   key_count;
	logic [WORD_W-1:0]     round_key [TABLE_SIZE];
	logic                  schedule_valid;

	block_words_t plain_expected [$];
	int           error_count;
	int           send_idle_pct;
	int           recv_stall_pct;
	int           hold_cycles;

	function automatic logic [WORD_W-1:0] rot_left(logic [WORD_W-1:0] x, logic [WORD_W-1:0] amt);
		int sh;
		sh = int'(amt[4:0]);
		if (sh == 0) begin
			return x;
		end
		return (x << sh) | (x >> (WORD_W - sh));
	endfunction

	function automatic logic [WORD_W-1:0] rot_right(logic [WORD_W-1:0] x, logic [WORD_W-1:0] amt);
		int sh;
		sh = int'(amt[4:0]);
		if (sh == 0) begin
			return x;
		end
		return (x >> sh) | (x << (WORD_W - sh));
	endfunction

	function automatic void expand_round_keys();
		logic [WORD_W-1:0] lw [MAX_KEY_WORDS];
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		int                i;
		int                j;
		int                words;
		words = int'(key_count);
		if (words == 0) begin
			words = 1;
		end
		if (words > MAX_KEY_WORDS) begin
			words = MAX_KEY_WORDS;
		end
		for (int k = 0; k < MAX_KEY_WORDS; k++) begin
			lw[k] = (k % 2 == 1) ? key_parts[k / 2][63:32] : key_parts[k / 2][31:0];
		end
		round_key[0] = MAGIC_P;
		for (int k = 1; k < TABLE_SIZE; k++) begin
			round_key[k] = round_key[k - 1] + MAGIC_Q;
		end
		a = '0;
		b = '0;
		i = 0;
		j = 0;
		for (int k = 0; k < 3 * ((TABLE_SIZE > words) ? TABLE_SIZE : words); k++) begin
			a = rot_left(round_key[i] + a + b, WORD_W'(KEY_ROT));
			round_key[i] = a;
			b = rot_left(lw[j] + a + b, a + b);
			lw[j] = b;
			i = (i + 1 >= TABLE_SIZE) ? 0 : i + 1;
			j = (j + 1 >= words) ? 0 : j + 1;
		end
		schedule_valid = 1'b1;
	endfunction

	function automatic block_words_t decrypt_block(block_words_t cw);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
		logic [WORD_W-1:0] tmp;
		logic [WORD_W-1:0] t;
		logic [WORD_W-1:0] u;
		logic [WORD_W-1:0] sq;
		block_words_t      pw;
		if (!schedule_valid) begin
			expand_round_keys();
		end
		a = cw.a;
		b = cw.b;
		c = cw.c - round_key[2 * ROUNDS + 3];
		d = cw.d;
		a = a - round_key[2 * ROUNDS + 2];
		for (int r = ROUNDS; r >= 1; r--) begin
			tmp = d;
			d = c;
			c = b;
			b = a;
			a = tmp;
			sq = d * ((d << 1) + 32'd1);
			u = rot_left(sq, WORD_W'(LG_W));
			sq = b * ((b << 1) + 32'd1);
			t = rot_left(sq, WORD_W'(LG_W));
			c = rot_right(c - round_key[2 * r + 1], t) ^ u;
			a = rot_right(a - round_key[2 * r], u) ^ t;
		end
		pw.a = a;
		pw.b = b - round_key[0];
		pw.c = c;
		pw.d = d - round_key[1];
		return pw;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[rc6_block_decrypt_core] ERROR");
		$finish;
	end

	initial begin
		plain_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				plain_bus.ready <= 1'b0;
				hold_cycles = hold_cycles - 1;
			end else begin
				plain_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic compare_word(string name, logic [WORD_W-1:0] exp_val, logic [WORD_W-1:0] act);
		if (exp_val !== act) begin
			$error("%s expected %h actual %h", name, exp_val, act);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		block_words_t exp_words;
		if (arst_n && plain_bus.valid && plain_bus.ready) begin
			if (plain_expected.size() == 0) begin
				$error("plaintext result with no request outstanding");
				error_count++;
			end else begin
				exp_words = plain_expected.pop_front();
				compare_word("plain_a", exp_words.a, plain_bus.plain_a);
				compare_word("plain_b", exp_words.b, plain_bus.plain_b);
				compare_word("plain_c", exp_words.c, plain_bus.plain_c);
				compare_word("plain_d", exp_words.d, plain_bus.plain_d);
			end
		end
	end

	task automatic send_block(block_words_t cw);
		if ($urandom_range(99) < send_idle_pct) begin
			cipher_bus.valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
		cipher_bus.valid    <= 1'b1;
		cipher_bus.cipher_a <= cw.a;
		cipher_bus.cipher_b <= cw.b;
		cipher_bus.cipher_c <= cw.c;
		cipher_bus.cipher_d <= cw.d;
		@(posedge clk);
		while (!cipher_bus.ready) begin
			@(posedge clk);
		end
		plain_expected.push_back(decrypt_block(cw));
	endtask

	task automatic send_random_block();
		block_words_t cw;
		cw = {$urandom, $urandom, $urandom, $urandom};
		send_block(cw);
	endtask

	task automatic drain_results();
		cipher_bus.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (plain_expected.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		if (idx <= REG_KEY_PART_LAST) begin
			key_parts[idx[1:0]] = data;
			schedule_valid = 1'b0;
		end else if (idx == REG_KEY_WORD_COUNT) begin
			key_count = data[KW_CNT_W-1:0];
			schedule_valid = 1'b0;
		end
	endtask

	task automatic end_writes();
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_key(logic [CFG_DATA_W-1:0] part_val, logic [KW_CNT_W-1:0] count);
		logic [CFG_DATA_W-1:0] filler;
		filler = {$urandom, $urandom};
		for (int k = 0; k < KEY_PARTS; k++) begin
			write_reg(REG_KEY_PART_0 + CFG_IDX_W'(k), part_val);
		end
		write_reg(REG_KEY_WORD_COUNT, {filler[CFG_DATA_W-1:KW_CNT_W], count});
		end_writes();
	endtask

	task automatic test_reset_key();
		send_block('0);
		send_block('1);
		send_block({4{32'hAAAA_5555}});
		send_block({32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000});
		send_block({32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678, 32'h8765_4321});
		send_random_block();
		drain_results();
	endtask

	task automatic test_key_extremes();
		logic [CFG_DATA_W-1:0] filler;
		load_key('0, 4'd0);
		send_block('0);
		send_block('1);
		send_random_block();
		drain_results();
		load_key('1, 4'd8);
		send_block('0);
		send_block('1);
		send_random_block();
		drain_results();
		load_key('1, 4'd15);
		send_block('0);
		send_random_block();
		drain_results();
		for (int k = 0; k < KEY_PARTS; k++) begin
			write_reg(REG_KEY_PART_0 + CFG_IDX_W'(k), {$urandom, $urandom});
		end
		filler = {$urandom, $urandom};
		write_reg(REG_KEY_WORD_COUNT, {filler[CFG_DATA_W-1:KW_CNT_W], 4'd1});
		end_writes();
		send_block('1);
		send_random_block();
		drain_results();
	endtask

	task automatic test_ignored_index();
		for (int idx = REG_KEY_WORD_COUNT + 1; idx <= REG_INDEX_MAX; idx++) begin
			write_reg(CFG_IDX_W'(idx), {$urandom, $urandom});
		end
		end_writes();
		send_random_block();
		send_random_block();
		send_random_block();
		drain_results();
	endtask

	task automatic test_output_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 400;
		for (int n = 0; n < 12; n++) begin
			send_random_block();
		end
		drain_results();
	endtask

	task automatic test_random_traffic();
		for (int round = 0; round < 12; round++) begin
			case (round % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 62;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 62;
				end
				default: begin
					send_idle_pct  = 16;
					recv_stall_pct = 16;
				end
			endcase
			for (int k = 0; k < KEY_PARTS; k++) begin
				if ($urandom_range(99) < 70) begin
					write_reg(REG_KEY_PART_0 + CFG_IDX_W'(k), {$urandom, $urandom});
				end
			end
			if ($urandom_range(99) < 70) begin
				write_reg(REG_KEY_WORD_COUNT, {$urandom, $urandom});
			end
			if ($urandom_range(99) < 20) begin
				write_reg(CFG_IDX_W'($urandom_range(REG_INDEX_MAX, REG_KEY_WORD_COUNT + 1)),
					{$urandom, $urandom});
			end
			end_writes();
			for (int n = 0; n < 75; n++) begin
				send_random_block();
			end
			drain_results();
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		cipher_bus.valid    = 1'b0;
		cipher_bus.cipher_a = '0;
		cipher_bus.cipher_b = '0;
		cipher_bus.cipher_c = '0;
		cipher_bus.cipher_d = '0;
		for (int k = 0; k < KEY_PARTS; k++) begin
			key_parts[k] = '0;
		end
		key_count      = 4'd4;
		schedule_valid = 1'b0;
		error_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_key();
		test_key_extremes();
		test_ignored_index();
		test_output_backpressure();
		test_random_traffic();

		repeat (BLOCK_LATENCY) @(posedge clk);
		if (plain_expected.size() != 0) begin
			$error("%0d plaintext results never arrived", plain_expected.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("[rc6_block_decrypt_core] OK");
		end else begin
			$display("[rc6_block_decrypt_core] ERROR");
		end
		$finish;
	end

endmodule
